// ===== rtl/vps_pkg.sv =====
`default_nettype none

package vps_pkg;

   // Command codes of a request word.
   localparam logic [2:0] CMD_MOVE_ABS  = 3'd0;
   localparam logic [2:0] CMD_LINE_ABS  = 3'd1;
   localparam logic [2:0] CMD_MOVE_REL  = 3'd2;
   localparam logic [2:0] CMD_LINE_REL  = 3'd3;
   localparam logic [2:0] CMD_TICK      = 3'd4;
   localparam logic [2:0] CMD_CALIBRATE = 3'd5;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_AREA_LEFT   = 3'd0;
   localparam logic [2:0] REG_AREA_RIGHT  = 3'd1;
   localparam logic [2:0] REG_AREA_TOP    = 3'd2;
   localparam logic [2:0] REG_AREA_BOTTOM = 3'd3;
   localparam logic [2:0] REG_SPACING     = 3'd4;
   localparam logic [2:0] REG_STEPS_UNIT  = 3'd5;
   localparam logic [2:0] REG_SETTLE      = 3'd6;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int COORD_W = 16;
   localparam int SPU_W   = 24;
   localparam int OUT_W   = 24;

   // Root unit: radicand is d2 * 2^16 with d2 below 2^33.
   localparam int ROOT_W = 25;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int PROD_W = ROOT_W + SPU_W;

   typedef struct packed {
      logic [COORD_W-1:0] area_left;
      logic [COORD_W-1:0] area_right;
      logic [COORD_W-1:0] area_top;
      logic [COORD_W-1:0] area_bottom;
      logic [COORD_W-1:0] motor_spacing;
      logic [SPU_W-1:0]   steps_per_unit;
      logic [COORD_W-1:0] pen_settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic             accepted;
      logic             busy_res;
      logic             pen_lowered;
      logic             pulse_left;
      logic             pulse_right;
      logic             lengthen_left;
      logic             lengthen_right;
      logic [OUT_W-1:0] count_left_out;
      logic [OUT_W-1:0] count_right_out;
   } rsp_type;

   // Clamp an axis value: the low limit first, then the high limit wins.
   function automatic logic [COORD_W-1:0] clamp_axis(input logic signed [COORD_W+1:0] v,
                                                     input logic [COORD_W-1:0] lo,
                                                     input logic [COORD_W-1:0] hi);
      logic signed [COORD_W+1:0] t;
      t = v;
      if (t < $signed({2'b00, lo})) begin
         t = $signed({2'b00, lo});
      end
      if (t > $signed({2'b00, hi})) begin
         t = $signed({2'b00, hi});
      end
      return t[COORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vps_if.sv =====
`default_nettype none

// Request channel: one command or tick word.
interface vps_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        command;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;

   modport source(output valid, output command, output coord_x, output coord_y,
                  input ready);
   modport sink(input valid, input command, input coord_x, input coord_y,
                output ready);
endinterface

// Response channel: one status word per request word.
interface vps_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        busy_res;
   logic        pen_lowered;
   logic        pulse_left;
   logic        pulse_right;
   logic        lengthen_left;
   logic        lengthen_right;
   logic [23:0] count_left_out;
   logic [23:0] count_right_out;

   modport source(output valid, output accepted, output busy_res, output pen_lowered,
                  output pulse_left, output pulse_right, output lengthen_left,
                  output lengthen_right, output count_left_out, output count_right_out,
                  input ready);
   modport sink(input valid, input accepted, input busy_res, input pen_lowered,
                input pulse_left, input pulse_right, input lengthen_left,
                input lengthen_right, input count_left_out, input count_right_out,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/vps_csr.sv =====
`default_nettype none

module vps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [vps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [vps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [vps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output vps_pkg::cfg_type                  cfg
);
   import vps_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_AREA_LEFT:   cfg_in.area_left        = pwdata[COORD_W-1:0];
            REG_AREA_RIGHT:  cfg_in.area_right       = pwdata[COORD_W-1:0];
            REG_AREA_TOP:    cfg_in.area_top         = pwdata[COORD_W-1:0];
            REG_AREA_BOTTOM: cfg_in.area_bottom      = pwdata[COORD_W-1:0];
            REG_SPACING:     cfg_in.motor_spacing    = pwdata[COORD_W-1:0];
            REG_STEPS_UNIT:  cfg_in.steps_per_unit   = pwdata[SPU_W-1:0];
            REG_SETTLE:      cfg_in.pen_settle_ticks = pwdata[COORD_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_left        <= '0;
         cfg_ff.area_right       <= 16'hFFFF;
         cfg_ff.area_top         <= '0;
         cfg_ff.area_bottom      <= 16'hFFFF;
         cfg_ff.motor_spacing    <= 16'd16000;
         cfg_ff.steps_per_unit   <= 24'h010000;
         cfg_ff.pen_settle_ticks <= 16'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read decode.
   always_comb begin
      unique case (reg_idx)
         REG_AREA_LEFT:   prdata = CSR_DATA_W'(cfg_ff.area_left);
         REG_AREA_RIGHT:  prdata = CSR_DATA_W'(cfg_ff.area_right);
         REG_AREA_TOP:    prdata = CSR_DATA_W'(cfg_ff.area_top);
         REG_AREA_BOTTOM: prdata = CSR_DATA_W'(cfg_ff.area_bottom);
         REG_SPACING:     prdata = CSR_DATA_W'(cfg_ff.motor_spacing);
         REG_STEPS_UNIT:  prdata = CSR_DATA_W'(cfg_ff.steps_per_unit);
         REG_SETTLE:      prdata = CSR_DATA_W'(cfg_ff.pen_settle_ticks);
         default:         prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/vps_root.sv =====
`default_nettype none

// Integer square root, one result bit per cycle.
module vps_root (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [vps_pkg::RAD_W-1:0]      radicand,
   output logic                           done,
   output logic [vps_pkg::ROOT_W-1:0]     root
);
   import vps_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W+1:0]  rem_shift;
   logic [REM_W+1:0]  trial;

   assign done = done_ff;
   assign root = root_ff;

   // Bring down the next two radicand bits and try the next root bit.
   assign rem_shift = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial     = (REM_W+2)'({root_ff, 2'b01});

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = REM_W'(rem_shift - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_shift);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

`default_nettype wire

// ===== rtl/v_plotter_move_stepper.sv =====
`default_nettype none

// Two-cable plotter move controller with a tick-driven stepper.
// A tick word or a refused command is answered in the cycle after it is taken.
// A taken command runs two cable lengths through one multiplier and a bit-serial
// square-root unit (states SQX, SQY, ROOT, SAT per side); COMMIT and RESP then send its word.
// Only one word is in work at a time; the square-root loop and output back-pressure set the command rate.
// Synchronous reset clears position, goals, pen (up), settle and control state, but not the payload registers.

module v_plotter_move_stepper #(
   parameter int STEP_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   vps_req_if.sink                           req,
   vps_rsp_if.source                         rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [vps_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [vps_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [vps_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import vps_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQX    = 3'd1;
   localparam logic [2:0] ST_SQY    = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_SAT    = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   localparam logic [32:0] STEP_MAX = (33'd1 << STEP_BITS) - 33'd1;

   cfg_type cfg;

   logic [2:0]           state_ff, state_in;
   logic                 side_ff, side_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [COORD_W-1:0]   tx_ff, tx_in, ty_ff, ty_in;
   logic [COORD_W-1:0]   last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [STEP_BITS-1:0] count_l_ff, count_l_in, count_r_ff, count_r_in;
   logic [STEP_BITS-1:0] goal_l_ff, goal_l_in, goal_r_ff, goal_r_in;
   logic                 pen_ff, pen_in;
   logic [COORD_W-1:0]   settle_ff, settle_in;
   logic [PROD_W-1:0]    mul_ff, mul_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_fire, out_free, busy_now, cmd_known;
   logic                 more_l, more_r, move_l, move_r, settling;
   logic [STEP_BITS-1:0] tick_count_l, tick_count_r;
   logic [COORD_W-1:0]   tick_settle;
   logic signed [COORD_W+1:0] sum_x, sum_y;
   logic [COORD_W:0]     mid_x, mid_y;
   logic [COORD_W-1:0]   clamp_x, clamp_y;
   logic signed [COORD_W:0] dx_right;
   logic [COORD_W-1:0]   ax;
   logic [ROOT_W-1:0]    mul_a;
   logic [SPU_W-1:0]     mul_b;
   logic [PROD_W-1:0]    product;
   logic [COORD_W*2:0]   d2;
   logic                 root_start, root_done;
   logic [ROOT_W-1:0]    root_val;
   logic [32:0]          g_wide;
   logic [STEP_BITS-1:0] goal_sat;
   logic                 new_pen;

   vps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vps_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({1'b0, d2, 16'b0}),
      .done     (root_done),
      .root     (root_val)
   );

   // Handshake: a new word is taken only when idle and the output register can load.
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req.valid && req.ready;

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.accepted        = rsp_ff.accepted;
   assign rsp.busy_res        = rsp_ff.busy_res;
   assign rsp.pen_lowered     = rsp_ff.pen_lowered;
   assign rsp.pulse_left      = rsp_ff.pulse_left;
   assign rsp.pulse_right     = rsp_ff.pulse_right;
   assign rsp.lengthen_left   = rsp_ff.lengthen_left;
   assign rsp.lengthen_right  = rsp_ff.lengthen_right;
   assign rsp.count_left_out  = rsp_ff.count_left_out;
   assign rsp.count_right_out = rsp_ff.count_right_out;

   // Current motion status.
   assign busy_now  = (settle_ff != '0) || (count_l_ff != goal_l_ff) ||
                      (count_r_ff != goal_r_ff);
   assign more_l    = goal_l_ff > count_l_ff;
   assign more_r    = goal_r_ff > count_r_ff;
   assign cmd_known = (req.command == CMD_MOVE_ABS) || (req.command == CMD_LINE_ABS) ||
                      (req.command == CMD_MOVE_REL) || (req.command == CMD_LINE_REL) ||
                      (req.command == CMD_CALIBRATE);

   // Tick: spend settle time first, otherwise step each motor toward its goal.
   assign settling     = settle_ff != '0;
   assign move_l       = !settling && (count_l_ff != goal_l_ff);
   assign move_r       = !settling && (count_r_ff != goal_r_ff);
   assign tick_settle  = settling ? settle_ff - 1'b1 : settle_ff;
   assign tick_count_l = !move_l ? count_l_ff :
                         (more_l ? count_l_ff + 1'b1 : count_l_ff - 1'b1);
   assign tick_count_r = !move_r ? count_r_ff :
                         (more_r ? count_r_ff + 1'b1 : count_r_ff - 1'b1);

   // Target: absolute or offset from the last target, clamped; calibrate takes the center.
   always_comb begin
      sum_x = $signed({{2{req.coord_x[COORD_W-1]}}, req.coord_x});
      sum_y = $signed({{2{req.coord_y[COORD_W-1]}}, req.coord_y});
      if ((req.command == CMD_MOVE_REL) || (req.command == CMD_LINE_REL)) begin
         sum_x = sum_x + $signed({2'b00, last_x_ff});
         sum_y = sum_y + $signed({2'b00, last_y_ff});
      end
   end

   assign mid_x   = {1'b0, cfg.area_left} + {1'b0, cfg.area_right};
   assign mid_y   = {1'b0, cfg.area_top} + {1'b0, cfg.area_bottom};
   assign clamp_x = clamp_axis(sum_x, cfg.area_left, cfg.area_right);
   assign clamp_y = clamp_axis(sum_y, cfg.area_top, cfg.area_bottom);

   // Horizontal distance from the motor on the current side.
   assign dx_right = $signed({1'b0, cfg.motor_spacing}) - $signed({1'b0, tx_ff});
   assign ax       = !side_ff ? tx_ff :
                     (dx_right[COORD_W] ? COORD_W'(-dx_right) : dx_right[COORD_W-1:0]);

   // Shared multiplier: squares of the two offsets, then root times steps per unit.
   always_comb begin
      case (state_ff)
         ST_SQX: begin
            mul_a = ROOT_W'(ax);
            mul_b = SPU_W'(ax);
         end
         ST_SQY: begin
            mul_a = ROOT_W'(ty_ff);
            mul_b = SPU_W'(ty_ff);
         end
         default: begin
            mul_a = root_val;
            mul_b = cfg.steps_per_unit;
         end
      endcase
   end

   assign product = mul_a * mul_b;
   assign d2      = mul_ff[COORD_W*2:0] + product[COORD_W*2:0];

   // Scale down and saturate the step goal.
   assign g_wide   = 33'(mul_ff[PROD_W-1:SPU_W]);
   assign goal_sat = (g_wide > STEP_MAX) ? STEP_BITS'(STEP_MAX) : STEP_BITS'(g_wide);
   assign new_pen  = (cmd_ff == CMD_LINE_ABS) || (cmd_ff == CMD_LINE_REL);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      cmd_in       = cmd_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      count_l_in   = count_l_ff;
      count_r_in   = count_r_ff;
      goal_l_in    = goal_l_ff;
      goal_r_in    = goal_r_ff;
      pen_in       = pen_ff;
      settle_in    = settle_ff;
      mul_in       = mul_ff;
      root_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.command == CMD_TICK) begin
                  settle_in  = tick_settle;
                  count_l_in = tick_count_l;
                  count_r_in = tick_count_r;
                  rsp_valid_in           = 1'b1;
                  rsp_in.accepted        = 1'b1;
                  rsp_in.busy_res        = (tick_settle != '0) ||
                                           (tick_count_l != goal_l_ff) ||
                                           (tick_count_r != goal_r_ff);
                  rsp_in.pen_lowered     = pen_ff;
                  rsp_in.pulse_left      = move_l;
                  rsp_in.pulse_right     = move_r;
                  rsp_in.lengthen_left   = more_l;
                  rsp_in.lengthen_right  = more_r;
                  rsp_in.count_left_out  = OUT_W'(tick_count_l);
                  rsp_in.count_right_out = OUT_W'(tick_count_r);
               end else if (cmd_known && !busy_now) begin
                  cmd_in = req.command;
                  if (req.command == CMD_CALIBRATE) begin
                     tx_in = mid_x[COORD_W:1];
                     ty_in = mid_y[COORD_W:1];
                  end else begin
                     tx_in = clamp_x;
                     ty_in = clamp_y;
                  end
                  side_in  = 1'b0;
                  state_in = ST_SQX;
               end else begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.accepted        = 1'b0;
                  rsp_in.busy_res        = busy_now;
                  rsp_in.pen_lowered     = pen_ff;
                  rsp_in.pulse_left      = 1'b0;
                  rsp_in.pulse_right     = 1'b0;
                  rsp_in.lengthen_left   = more_l;
                  rsp_in.lengthen_right  = more_r;
                  rsp_in.count_left_out  = OUT_W'(count_l_ff);
                  rsp_in.count_right_out = OUT_W'(count_r_ff);
               end
            end
         end
         ST_SQX: begin
            mul_in   = product;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            root_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_done) begin
               mul_in   = product;
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (!side_ff) begin
               goal_l_in = goal_sat;
               side_in   = 1'b1;
               state_in  = ST_SQX;
            end else begin
               goal_r_in = goal_sat;
               state_in  = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            last_x_in = tx_ff;
            last_y_in = ty_ff;
            if (cmd_ff == CMD_CALIBRATE) begin
               count_l_in = goal_l_ff;
               count_r_in = goal_r_ff;
            end
            if (pen_ff != new_pen) begin
               settle_in = cfg.pen_settle_ticks;
            end
            pen_in   = new_pen;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.accepted        = 1'b1;
               rsp_in.busy_res        = busy_now;
               rsp_in.pen_lowered     = pen_ff;
               rsp_in.pulse_left      = 1'b0;
               rsp_in.pulse_right     = 1'b0;
               rsp_in.lengthen_left   = more_l;
               rsp_in.lengthen_right  = more_r;
               rsp_in.count_left_out  = OUT_W'(count_l_ff);
               rsp_in.count_right_out = OUT_W'(count_r_ff);
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and machine state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         count_l_ff   <= '0;
         count_r_ff   <= '0;
         goal_l_ff    <= '0;
         goal_r_ff    <= '0;
         pen_ff       <= 1'b0;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         count_l_ff   <= count_l_in;
         count_r_ff   <= count_r_in;
         goal_l_ff    <= goal_l_in;
         goal_r_ff    <= goal_r_in;
         pen_ff       <= pen_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      tx_ff  <= tx_in;
      ty_ff  <= ty_in;
      mul_ff <= mul_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== test/v_plotter_move_stepper_test.sv =====
`timescale 1ns / 100ps

module v_plotter_move_stepper_test;
   import vps_pkg::*;

   localparam int STEP_BITS = 24;

   // The two command codes that the block must refuse.
   localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

   // Largest number of ticks one random command may leave pending.
   localparam int MOVE_BUDGET = 64;
   localparam int RANDOM_WORDS = 180;
   localparam int HOLD_CYCLES = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 100;

   // Tracks cable step counts, goals, pen and settle time, and holds the
   // status words that the block still owes.
   class cable_motion_tracker;
      logic [15:0] left_edge, right_edge, top_edge, bottom_edge;
      logic [15:0] spacing, settle_ticks;
      logic [23:0] spu;
      logic [15:0] last_x, last_y;
      logic [23:0] pos_left, pos_right, aim_left, aim_right;
      logic        pen_low;
      logic [15:0] settle_left;
      rsp_type     awaited_status[$];
      int          mismatches, orphans, checked, refused;

      function new();
         left_edge = 16'd0;
         right_edge = 16'hFFFF;
         top_edge = 16'd0;
         bottom_edge = 16'hFFFF;
         spacing = 16'd16000;
         spu = 24'd65536;
         settle_ticks = 16'd50;
         last_x = '0;
         last_y = '0;
         pos_left = '0;
         pos_right = '0;
         aim_left = '0;
         aim_right = '0;
         pen_low = 1'b0;
         settle_left = '0;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            REG_AREA_LEFT: left_edge = value[15:0];
            REG_AREA_RIGHT: right_edge = value[15:0];
            REG_AREA_TOP: top_edge = value[15:0];
            REG_AREA_BOTTOM: bottom_edge = value[15:0];
            REG_SPACING: spacing = value[15:0];
            REG_STEPS_UNIT: spu = value[23:0];
            REG_SETTLE: settle_ticks = value[15:0];
            default: ;
         endcase
      endfunction

      function bit is_busy();
         return settle_left != 0 || pos_left != aim_left || pos_right != aim_right;
      endfunction

      // Integer square root, two radicand bits per round.
      function longint unsigned int_root(longint unsigned v);
         longint unsigned rem, acc, trial;
         rem = 0;
         acc = 0;
         for (int i = 31; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            trial = (acc << 2) | 64'd1;
            if (rem >= trial) begin
               rem = rem - trial;
               acc = (acc << 1) | 64'd1;
            end else begin
               acc = acc << 1;
            end
         end
         return acc;
      endfunction

      // Step goal for a cable of the given offsets from its motor.
      function logic [23:0] cable_steps(longint dx, longint dy);
         longint unsigned ax, ay, r, g;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         r = int_root((ax * ax + ay * ay) << 16);
         g = (r * spu) >> 24;
         if (g > ((64'd1 << STEP_BITS) - 1)) begin
            g = (64'd1 << STEP_BITS) - 1;
         end
         return g[23:0];
      endfunction

      // Low limit first, then the high limit, so inverted limits favor the high one.
      function longint fit(longint v, logic [15:0] lo, logic [15:0] hi);
         longint lo_s, hi_s;
         lo_s = longint'(lo);
         hi_s = longint'(hi);
         if (v < lo_s) begin
            v = lo_s;
         end
         if (v > hi_s) begin
            v = hi_s;
         end
         return v;
      endfunction

      function void target(logic [2:0] cmd, logic signed [15:0] x, logic signed [15:0] y,
                           output longint tx, output longint ty);
         if (cmd == CMD_CALIBRATE) begin
            tx = (longint'(left_edge) + longint'(right_edge)) >>> 1;
            ty = (longint'(top_edge) + longint'(bottom_edge)) >>> 1;
         end else begin
            tx = longint'(x);
            ty = longint'(y);
            if (cmd == CMD_MOVE_REL || cmd == CMD_LINE_REL) begin
               tx = tx + longint'(last_x);
               ty = ty + longint'(last_y);
            end
            tx = fit(tx, left_edge, right_edge);
            ty = fit(ty, top_edge, bottom_edge);
         end
      endfunction

      // Ticks that a command would leave pending if it were taken now.
      function longint cost(logic [2:0] cmd, logic signed [15:0] x, logic signed [15:0] y);
         longint tx, ty, dl, dr, c;
         logic [23:0] gl, gr;
         logic down;
         target(cmd, x, y, tx, ty);
         gl = cable_steps(tx, ty);
         gr = cable_steps(longint'(spacing) - tx, ty);
         down = (cmd == CMD_LINE_ABS || cmd == CMD_LINE_REL);
         c = 0;
         if (cmd != CMD_CALIBRATE) begin
            dl = longint'(gl) - longint'(pos_left);
            dr = longint'(gr) - longint'(pos_right);
            dl = (dl < 0) ? -dl : dl;
            dr = (dr < 0) ? -dr : dr;
            c = (dl > dr) ? dl : dr;
         end
         if (down != pen_low) begin
            c = c + longint'(settle_ticks);
         end
         return c;
      endfunction

      // Applies one request word that the block has taken and queues the status it must produce.
      function void take_word(logic [2:0] cmd, logic signed [15:0] x, logic signed [15:0] y);
         rsp_type e;
         logic was_busy, down;
         longint tx, ty;
         was_busy = is_busy();
         e = '0;
         e.lengthen_left = aim_left > pos_left;
         e.lengthen_right = aim_right > pos_right;
         if (cmd == CMD_TICK) begin
            e.accepted = 1'b1;
            if (settle_left != 0) begin
               settle_left = settle_left - 1'b1;
            end else begin
               if (pos_left != aim_left) begin
                  e.pulse_left = 1'b1;
                  pos_left = e.lengthen_left ? pos_left + 1'b1 : pos_left - 1'b1;
               end
               if (pos_right != aim_right) begin
                  e.pulse_right = 1'b1;
                  pos_right = e.lengthen_right ? pos_right + 1'b1 : pos_right - 1'b1;
               end
            end
         end else if (cmd <= CMD_CALIBRATE && !was_busy) begin
            e.accepted = 1'b1;
            target(cmd, x, y, tx, ty);
            last_x = tx[15:0];
            last_y = ty[15:0];
            aim_left = cable_steps(tx, ty);
            aim_right = cable_steps(longint'(spacing) - tx, ty);
            if (cmd == CMD_CALIBRATE) begin
               pos_left = aim_left;
               pos_right = aim_right;
            end
            down = (cmd == CMD_LINE_ABS || cmd == CMD_LINE_REL);
            if (down != pen_low) begin
               settle_left = settle_ticks;
            end
            pen_low = down;
            e.lengthen_left = aim_left > pos_left;
            e.lengthen_right = aim_right > pos_right;
         end else begin
            refused++;
         end
         e.busy_res = is_busy();
         e.pen_lowered = pen_low;
         e.count_left_out = pos_left;
         e.count_right_out = pos_right;
         awaited_status.insert(awaited_status.size(), e);
      endfunction

      // Compares one status word from the block with the oldest one owed.
      function void check_status(rsp_type got);
         rsp_type e;
         if (awaited_status.size() == 0) begin
            orphans++;
            if (mismatches + orphans <= 10) begin
               $display("%0t: status word with none owed: %h", $realtime, got);
            end
            return;
         end
         e = awaited_status.pop_front();
         checked++;
         if (got.accepted !== e.accepted || got.busy_res !== e.busy_res ||
             got.pen_lowered !== e.pen_lowered || got.pulse_left !== e.pulse_left ||
             got.pulse_right !== e.pulse_right || got.lengthen_left !== e.lengthen_left ||
             got.lengthen_right !== e.lengthen_right ||
             got.count_left_out !== e.count_left_out ||
             got.count_right_out !== e.count_right_out) begin
            mismatches++;
            if (mismatches + orphans <= 10) begin
               $display("%0t: status %0d mismatch (expected/actual): acc %b/%b busy %b/%b",
                        $realtime, checked, e.accepted, got.accepted, e.busy_res,
                        got.busy_res);
               $display("   pen %b/%b pulse %b%b/%b%b dir %b%b/%b%b left %0d/%0d right %0d/%0d",
                        e.pen_lowered, got.pen_lowered, e.pulse_left, e.pulse_right,
                        got.pulse_left, got.pulse_right, e.lengthen_left, e.lengthen_right,
                        got.lengthen_left, got.lengthen_right, e.count_left_out,
                        got.count_left_out, e.count_right_out, got.count_right_out);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   vps_req_if req();
   vps_rsp_if rsp();

   cable_motion_tracker tracker = new();

   int words_sent = 0;
   int results_seen = 0;
   int settings_applied = 0;
   int csr_mismatches = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 87;

   v_plotter_move_stepper #(.STEP_BITS(STEP_BITS)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Register write followed by a read back of the same register.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_STEPS_UNIT) ? 32'h00FF_FFFF : 32'h0000_FFFF;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      tracker.set_register(idx, value);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== (value & mask)) begin
         csr_mismatches++;
         $display("%0t: register %0d reads %h, wrote %h", $realtime, idx, prdata, value);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [15:0] left, logic [15:0] right, logic [15:0] top,
                                logic [15:0] bottom, logic [15:0] motor_gap,
                                logic [23:0] steps_unit, logic [15:0] settle);
      csr_write(REG_AREA_LEFT, {16'd0, left});
      csr_write(REG_AREA_RIGHT, {16'd0, right});
      csr_write(REG_AREA_TOP, {16'd0, top});
      csr_write(REG_AREA_BOTTOM, {16'd0, bottom});
      csr_write(REG_SPACING, {16'd0, motor_gap});
      csr_write(REG_STEPS_UNIT, {8'd0, steps_unit});
      csr_write(REG_SETTLE, {16'd0, settle});
      settings_applied++;
   endtask

   // Offers one request word and waits until the block takes it. Valid is
   // left high so that a following word can go out in the next cycle.
   task automatic send_word(logic [2:0] cmd, logic [15:0] x, logic [15:0] y);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.coord_x <= x;
      req.coord_y <= y;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      tracker.take_word(cmd, x, y);
      words_sent++;
      // Sender slow and receiver slower, then the reverse, then full speed.
      if (words_sent < 450) begin
         send_idle_pct = 37;
         recv_idle_pct = 87;
      end else if (words_sent < 900) begin
         send_idle_pct = 87;
         recv_idle_pct = 37;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   task automatic run_ticks();
      while (tracker.is_busy()) begin
         send_word(CMD_TICK, 16'($urandom), 16'($urandom));
      end
   endtask

   // Stops offering and waits until every owed status word has come back.
   task automatic wait_all_status();
      req.valid <= 1'b0;
      while (tracker.awaited_status.size() != 0) @(posedge clock);
   endtask

   // Finishes all pending motion, raises the pen and lets the block go quiet.
   task automatic close_phase();
      run_ticks();
      if (tracker.pen_low) begin
         send_word(CMD_MOVE_REL, 16'd0, 16'd0);
         run_ticks();
      end
      wait_all_status();
   endtask

   function automatic logic [2:0] any_command();
      case ($urandom_range(0, 4))
         0: return CMD_MOVE_ABS;
         1: return CMD_LINE_ABS;
         2: return CMD_MOVE_REL;
         3: return CMD_LINE_REL;
         default: return CMD_CALIBRATE;
      endcase
   endfunction

   // Picks a command whose pending motion stays within budget. Coordinates
   // start wide and narrow around the last target; a null relative move
   // with the current pen is the fallback.
   task automatic pick_command(output logic [2:0] cmd, output logic [15:0] x,
                               output logic [15:0] y);
      int span;
      longint cx, cy;
      bit rel;
      cmd = any_command();
      rel = (cmd == CMD_MOVE_REL || cmd == CMD_LINE_REL);
      for (int attempt = 0; attempt < 8; attempt++) begin
         if (attempt == 0 && $urandom_range(0, 1) == 1) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else begin
            span = 512 >> attempt;
            cx = longint'(int'($urandom_range(0, 2 * span)) - span);
            cy = longint'(int'($urandom_range(0, 2 * span)) - span);
            if (!rel) begin
               cx = cx + longint'(tracker.last_x);
               cy = cy + longint'(tracker.last_y);
            end
            x = cx[15:0];
            y = cy[15:0];
         end
         if (tracker.cost(cmd, x, y) <= MOVE_BUDGET) begin
            return;
         end
      end
      cmd = tracker.pen_low ? CMD_LINE_REL : CMD_MOVE_REL;
      x = 16'd0;
      y = 16'd0;
   endtask

   // Mostly valid commands and the ticks they need, with refused commands mixed in
   // while the motors are moving and unknown commands mixed in at all times.
   task automatic random_phase(int count);
      logic [2:0] cmd;
      logic [15:0] x, y;
      int r;
      send_word(CMD_CALIBRATE, 16'($urandom), 16'($urandom));
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (tracker.is_busy()) begin
            if (r < 8) begin
               send_word(any_command(), 16'($urandom), 16'($urandom));
            end else if (r < 11) begin
               send_word($urandom_range(0, 1) ? CMD_UNUSED_LO : CMD_UNUSED_HI,
                         16'($urandom), 16'($urandom));
            end else begin
               send_word(CMD_TICK, 16'($urandom), 16'($urandom));
            end
         end else begin
            if (r < 70) begin
               pick_command(cmd, x, y);
               send_word(cmd, x, y);
            end else if (r < 90) begin
               send_word(CMD_TICK, 16'($urandom), 16'($urandom));
            end else begin
               send_word($urandom_range(0, 1) ? CMD_UNUSED_LO : CMD_UNUSED_HI,
                         16'($urandom), 16'($urandom));
            end
         end
      end
      close_phase();
   endtask

   // Status receiver with random back-pressure and a few long hold-offs.
   initial begin : status_sink
      int hold_left;
      rsp_type got;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
         end else begin
            if (rsp.valid && rsp.ready) begin
               got = {rsp.accepted, rsp.busy_res, rsp.pen_lowered, rsp.pulse_left,
                      rsp.pulse_right, rsp.lengthen_left, rsp.lengthen_right,
                      rsp.count_left_out, rsp.count_right_out};
               tracker.check_status(got);
               results_seen++;
               if (results_seen % 500 == 250) begin
                  hold_left = HOLD_CYCLES;
               end
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
         end
      end
   end

   // Ends the run if nothing moves on any port for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
      $display("v_plotter_move_stepper_test: FAIL");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req.valid <= 1'b0;
      req.command <= CMD_TICK;
      req.coord_x <= '0;
      req.coord_y <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed words in a small area with slow steps and a short settle.
      apply_setting(16'd100, 16'd300, 16'd200, 16'd400, 16'd400, 24'd1024, 16'd2);
      send_word(CMD_TICK, 16'h7FFF, 16'h8000);
      send_word(CMD_UNUSED_LO, 16'hFFFF, 16'h0000);
      send_word(CMD_UNUSED_HI, 16'h0000, 16'hFFFF);
      // Calibrate ignores its coordinates and jumps to the area center.
      send_word(CMD_CALIBRATE, 16'h8000, 16'h7FFF);
      // Most negative target clamps to the low limits.
      send_word(CMD_MOVE_ABS, 16'h8000, 16'h8000);
      run_ticks();
      // Most positive target clamps high and lowers the pen, so the block is busy.
      send_word(CMD_LINE_ABS, 16'h7FFF, 16'h7FFF);
      send_word(CMD_MOVE_REL, 16'd5, 16'd5);
      send_word(CMD_CALIBRATE, 16'd0, 16'd0);
      run_ticks();
      send_word(CMD_LINE_REL, -16'sd50, 16'sd20);
      run_ticks();
      // Relative offsets that overflow 16 bits before clamping.
      send_word(CMD_MOVE_REL, 16'h7FFF, 16'h8000);
      run_ticks();
      send_word(CMD_MOVE_ABS, 16'd150, 16'd250);
      close_phase();

      // Register settings: reset values, small windows, zero scale, inverted
      // and saturating limits, a single-point area with maximum settle.
      apply_setting(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd16000, 24'd65536, 16'd50);
      random_phase(RANDOM_WORDS);
      apply_setting(16'd1000, 16'd1400, 16'd2000, 16'd2300, 16'd2400, 24'd2048, 16'd3);
      random_phase(RANDOM_WORDS);
      apply_setting(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 24'd0, 16'd0);
      random_phase(RANDOM_WORDS);
      apply_setting(16'hFFFF, 16'd60000, 16'hFFFF, 16'd50000, 16'd0, 24'hFFFFFF, 16'd1);
      random_phase(RANDOM_WORDS);
      apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'd300, 16'hFFFF);
      random_phase(RANDOM_WORDS);
      apply_setting(16'd200, 16'd900, 16'd50, 16'd700, 16'd1100, 24'd1000, 16'd7);
      random_phase(RANDOM_WORDS);
      apply_setting(16'd0, 16'd200, 16'd0, 16'd200, 16'd100, 24'd20000, 16'd2);
      random_phase(RANDOM_WORDS);

      wait_all_status();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.awaited_status.size() != 0) begin
         $display("%0d status words never arrived.", tracker.awaited_status.size());
      end

      $display("Sent %0d request words under %0d register settings; %0d statuses checked.",
               words_sent, settings_applied, tracker.checked);
      $display("Commands refused: %0d. Mismatches: %0d, unowed statuses: %0d, bad reads: %0d.",
               tracker.refused, tracker.mismatches, tracker.orphans, csr_mismatches);
      if (tracker.mismatches == 0 && tracker.orphans == 0 && csr_mismatches == 0 &&
          tracker.awaited_status.size() == 0) begin
         $display("v_plotter_move_stepper_test: PASS");
      end else begin
         $display("v_plotter_move_stepper_test: FAIL");
      end
      $finish;
   end

endmodule
